// File: sv/lobm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lobm_pkg: shared types and constants for the order book matcher
// Book sizes, field widths, controller states, datapath ops and status.
// ----------------------------------------------------------------------------
package lobm_pkg;

  // Sizes; ORDER_SLOTS and PRICE_LEVELS are powers of two.
  localparam int ORDER_SLOTS  = 1024;
  localparam int PRICE_LEVELS = 256;
  localparam int QTY_BITS     = 32;

  localparam int ID_W    = $clog2(ORDER_SLOTS);
  localparam int PRICE_W = $clog2(PRICE_LEVELS);
  localparam int LVL_N   = 2 * PRICE_LEVELS;
  localparam int LVL_W   = PRICE_W + 1;
  localparam int CLR_N   = (ORDER_SLOTS > LVL_N) ? ORDER_SLOTS : LVL_N;
  localparam int CLR_W   = $clog2(CLR_N);

  // Port field widths
  localparam int IN_PRICE_W = 8;
  localparam int IN_QTY_W   = 32;
  localparam int IN_ID_W    = 10;
  localparam int CNT_W      = 11;

  typedef enum logic {
    CMD_NEW    = 1'b0,
    CMD_MODIFY = 1'b1
  } cmd_t;

  typedef enum logic {
    SIDE_BUY  = 1'b0,
    SIDE_SELL = 1'b1
  } side_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_DISP,
    S_MOD,
    S_QCHK,
    S_LRD,
    S_LCHK,
    S_HRD,
    S_TRADE,
    S_ADV,
    S_FIN,
    S_OWN,
    S_ENQ
  } state_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_CLEAR,
    OP_LOAD,
    OP_MODIFY,
    OP_RD_IDQ,
    OP_INIT_LVL,
    OP_RD_LVL,
    OP_TAKE_LVL,
    OP_RD_HEAD,
    OP_TRADE,
    OP_NEXT_LVL,
    OP_RD_OWN,
    OP_ENQ,
    OP_FINISH
  } dp_op_t;

  typedef struct packed {
    logic is_modify;
    logic idq_hit;
    logic qty_zero;
    logic occ;
    logic last_lvl;
    logic res_zero;
    logic head_is_tail;
    logic qty_le_res;
    logic out_busy;
    logic clr_last;
  } dp_stat_t;

endpackage

// File: sv/lobm_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lobm_ram: generic simple dual-port RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module lobm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: sv/lobm_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lobm_dp: order book datapath
// Book memories, working registers, trade arithmetic and result register.
// ----------------------------------------------------------------------------
module lobm_dp (
  input  logic                            clk,
  input  logic                            rst_n,
  input  lobm_pkg::dp_op_t                op,
  input  logic                            in_command,
  input  logic                            in_side,
  input  logic [lobm_pkg::IN_PRICE_W-1:0] in_limit_price,
  input  logic [lobm_pkg::IN_QTY_W-1:0]   in_quantity,
  input  logic [lobm_pkg::IN_ID_W-1:0]    in_order_id,
  input  logic                            out_ready,
  output lobm_pkg::dp_stat_t              stat,
  output logic                            out_valid,
  output logic [lobm_pkg::CNT_W-1:0]      out_fill_count,
  output logic [lobm_pkg::IN_QTY_W-1:0]   out_remaining_quantity,
  output logic                            out_rested
);
  import lobm_pkg::*;

  logic                cmd_r;
  logic                side_r;
  logic [PRICE_W-1:0]  price_r;
  logic [QTY_BITS-1:0] qty_r, qty_nxt;
  logic [ID_W-1:0]     id_r;
  logic [PRICE_W-1:0]  p_r, p_nxt;
  logic [ID_W-1:0]     h_r, t_r;
  logic [CNT_W-1:0]    cnt_r;
  logic [CLR_W-1:0]    clr_r;
  logic                out_valid_r;
  logic [CNT_W-1:0]    out_cnt_r;
  logic [IN_QTY_W-1:0] out_qty_r;
  logic                out_rested_r;

  logic [LVL_W-1:0]    book_lvl, own_lvl;
  logic [QTY_BITS-1:0] take, res_left;
  logic                result_op;

  // memory ports
  logic idq_we, idq_wd, idq_q;
  logic [ID_W-1:0] idq_wa;
  logic occ_we, occ_wd, occ_q;
  logic [LVL_W-1:0] occ_wa, lvl_ra;
  logic head_we;
  logic [LVL_W-1:0] head_wa;
  logic [ID_W-1:0] head_wd, head_q;
  logic tail_we;
  logic [ID_W-1:0] tail_q;
  logic rq_we;
  logic [ID_W-1:0] rq_wa;
  logic [QTY_BITS-1:0] rq_wd, rq_q;
  logic nq_we;
  logic [ID_W-1:0] nq_q;

  // a buy order walks the sell half, a sell order the buy half
  assign book_lvl = {~side_r, p_r};
  assign own_lvl  = {side_r, price_r};
  assign lvl_ra   = (op == OP_RD_OWN) ? own_lvl : book_lvl;

  assign take     = (qty_r < rq_q) ? qty_r : rq_q;
  assign res_left = rq_q - take;

  assign result_op = (op == OP_MODIFY) || (op == OP_FINISH) || (op == OP_ENQ);

  always_comb begin
    idq_we = 1'b0; idq_wa = id_r; idq_wd = 1'b0;
    occ_we = 1'b0; occ_wa = book_lvl; occ_wd = 1'b0;
    head_we = 1'b0; head_wa = book_lvl; head_wd = nq_q;
    tail_we = 1'b0;
    rq_we = 1'b0; rq_wa = id_r; rq_wd = qty_r;
    nq_we = 1'b0;
    case (op)
      OP_CLEAR: begin
        idq_we = 1'b1; idq_wa = ID_W'(clr_r);
        occ_we = 1'b1; occ_wa = LVL_W'(clr_r);
      end
      OP_MODIFY: begin
        rq_we = 1'b1;
      end
      OP_TRADE: begin
        rq_we = 1'b1; rq_wa = h_r; rq_wd = res_left;
        if (res_left == '0) begin
          idq_we = 1'b1; idq_wa = h_r;
          if (h_r == t_r) begin
            occ_we = 1'b1;
          end else begin
            head_we = 1'b1;
          end
        end
      end
      OP_ENQ: begin
        rq_we = 1'b1;
        idq_we = 1'b1; idq_wd = 1'b1;
        tail_we = 1'b1;
        if (occ_q) begin
          nq_we = 1'b1;
        end else begin
          head_we = 1'b1; head_wa = own_lvl; head_wd = id_r;
          occ_we = 1'b1; occ_wa = own_lvl; occ_wd = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  lobm_ram #(.WIDTH(1), .DEPTH(ORDER_SLOTS)) u_idq (
    .clk, .we(idq_we), .waddr(idq_wa), .wdata(idq_wd), .raddr(id_r), .rdata(idq_q)
  );
  lobm_ram #(.WIDTH(1), .DEPTH(LVL_N)) u_occ (
    .clk, .we(occ_we), .waddr(occ_wa), .wdata(occ_wd), .raddr(lvl_ra), .rdata(occ_q)
  );
  lobm_ram #(.WIDTH(ID_W), .DEPTH(LVL_N)) u_head (
    .clk, .we(head_we), .waddr(head_wa), .wdata(head_wd), .raddr(lvl_ra), .rdata(head_q)
  );
  lobm_ram #(.WIDTH(ID_W), .DEPTH(LVL_N)) u_tail (
    .clk, .we(tail_we), .waddr(own_lvl), .wdata(id_r), .raddr(lvl_ra), .rdata(tail_q)
  );
  lobm_ram #(.WIDTH(QTY_BITS), .DEPTH(ORDER_SLOTS)) u_rq (
    .clk, .we(rq_we), .waddr(rq_wa), .wdata(rq_wd), .raddr(h_r), .rdata(rq_q)
  );
  lobm_ram #(.WIDTH(ID_W), .DEPTH(ORDER_SLOTS)) u_nq (
    .clk, .we(nq_we), .waddr(tail_q), .wdata(id_r), .raddr(h_r), .rdata(nq_q)
  );

  always_comb begin
    qty_nxt = qty_r;
    if (op == OP_TRADE) begin
      qty_nxt = qty_r - take;
    end
    p_nxt = p_r;
    if (op == OP_INIT_LVL) begin
      p_nxt = side_r ? '1 : '0;
    end else if (op == OP_NEXT_LVL) begin
      p_nxt = side_r ? p_r - 1'b1 : p_r + 1'b1;
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    if (op == OP_LOAD) begin
      cmd_r   <= in_command;
      side_r  <= in_side;
      price_r <= (32'(in_limit_price) >= PRICE_LEVELS) ? PRICE_W'(PRICE_LEVELS - 1)
                                                       : PRICE_W'(in_limit_price);
      qty_r   <= QTY_BITS'(in_quantity);
      id_r    <= ID_W'(in_order_id);
      cnt_r   <= '0;
    end else begin
      qty_r <= qty_nxt;
      if (op == OP_TRADE && cnt_r != '1) begin
        cnt_r <= cnt_r + 1'b1;
      end
    end
    p_r <= p_nxt;
    if (op == OP_TAKE_LVL) begin
      h_r <= head_q;
      t_r <= tail_q;
    end else if (op == OP_TRADE) begin
      h_r <= nq_q;
    end
  end

  // clear sweep counter and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (op == OP_CLEAR) begin
        clr_r <= clr_r + 1'b1;
      end
      if (result_op) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (result_op) begin
      out_cnt_r    <= (op == OP_MODIFY) ? '0 : cnt_r;
      out_qty_r    <= IN_QTY_W'(qty_r);
      out_rested_r <= (op == OP_ENQ);
    end
  end

  assign stat.is_modify    = (cmd_r == CMD_MODIFY);
  assign stat.idq_hit      = idq_q;
  assign stat.qty_zero     = (qty_r == '0);
  assign stat.occ          = occ_q;
  assign stat.last_lvl     = (p_r == price_r);
  assign stat.res_zero     = (rq_q <= qty_r);
  assign stat.head_is_tail = (h_r == t_r);
  assign stat.qty_le_res   = (qty_r <= rq_q);
  assign stat.out_busy     = out_valid_r && !out_ready;
  assign stat.clr_last     = (clr_r == CLR_W'(CLR_N - 1));

  assign out_valid              = out_valid_r;
  assign out_fill_count         = out_cnt_r;
  assign out_remaining_quantity = out_qty_r;
  assign out_rested             = out_rested_r;

  // a result must never land on one still waiting
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    result_op |-> !stat.out_busy) else $error("result overwritten");

  // a partial fill of the resting order exhausts the incoming one
  a_partial_empties: assert property (@(posedge clk) disable iff (!rst_n)
    (op == OP_TRADE && res_left != '0) |=> (qty_r == '0)) else $error("qty left");

  a_valid_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(result_op)) else $error("spurious result");

endmodule

// File: sv/lobm_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lobm_ctrl: order book sequencer
// Clear sweep, then per item: dispatch, modify or level walk, queue walk, rest.
// ----------------------------------------------------------------------------
module lobm_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  lobm_pkg::dp_stat_t stat,
  output lobm_pkg::dp_op_t   op,
  output logic               in_ready
);
  import lobm_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    op        = OP_NONE;
    in_ready  = 1'b0;
    case (state_r)
      S_CLEAR: begin
        op = OP_CLEAR;
        if (stat.clr_last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          op = OP_LOAD;
          state_nxt = S_DISP;
        end
      end
      S_DISP: begin
        if (stat.is_modify) begin
          state_nxt = S_MOD;
        end else begin
          op = OP_RD_IDQ;
          state_nxt = S_QCHK;
        end
      end
      S_MOD: begin
        if (!stat.out_busy) begin
          op = OP_MODIFY;
          state_nxt = S_IDLE;
        end
      end
      S_QCHK: begin
        if (stat.idq_hit || stat.qty_zero) begin
          state_nxt = S_FIN;
        end else begin
          op = OP_INIT_LVL;
          state_nxt = S_LRD;
        end
      end
      S_LRD: begin
        op = OP_RD_LVL;
        state_nxt = S_LCHK;
      end
      S_LCHK: begin
        if (stat.occ) begin
          op = OP_TAKE_LVL;
          state_nxt = S_HRD;
        end else begin
          state_nxt = S_ADV;
        end
      end
      S_HRD: begin
        op = OP_RD_HEAD;
        state_nxt = S_TRADE;
      end
      S_TRADE: begin
        op = OP_TRADE;
        if (!stat.res_zero || stat.qty_le_res) state_nxt = S_FIN;
        else if (stat.head_is_tail)            state_nxt = S_ADV;
        else                                   state_nxt = S_HRD;
      end
      S_ADV: begin
        if (stat.qty_zero) begin
          state_nxt = S_FIN;
        end else if (stat.last_lvl) begin
          state_nxt = S_OWN;
        end else begin
          op = OP_NEXT_LVL;
          state_nxt = S_LRD;
        end
      end
      S_FIN: begin
        if (!stat.out_busy) begin
          op = OP_FINISH;
          state_nxt = S_IDLE;
        end
      end
      S_OWN: begin
        op = OP_RD_OWN;
        state_nxt = S_ENQ;
      end
      S_ENQ: begin
        if (stat.out_busy) begin
          op = OP_RD_OWN;
        end else begin
          op = OP_ENQ;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

// File: sv/limit_order_book_matcher.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// limit_order_book_matcher: price-time priority limit order book
// Two-sided book with per-tick FIFO queues; matches, rests and modifies.
// ----------------------------------------------------------------------------
// Usage:
//   in_* is a valid/ready channel; one beat is a new order or a quantity
//   modify. out_* returns exactly one beat per input beat, in order:
//   fill count, remaining quantity and a rested flag.
//   Flow: a new order walks the price levels of the opposite side one
//   level at a time, from the most favourable level up to its limit (at
//   most 256 levels), and at each occupied level walks the resting orders
//   through the linked list; a remainder left after the walk rests. One
//   item is processed at a time.
//   Reset: after rst_n a clearing sweep over 1024 addresses wipes the
//   occupancy and queued-id memories; in_ready stays low meanwhile.
//   Stall: the result sits in an output register; the next beat is accepted
//   while it waits, and the block holds before writing its own result
//   until the waiting one has been taken.
// ----------------------------------------------------------------------------
module limit_order_book_matcher (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_command,
  input  logic        in_side,
  input  logic [7:0]  in_limit_price,
  input  logic [31:0] in_quantity,
  input  logic [9:0]  in_order_id,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [10:0] out_fill_count,
  output logic [31:0] out_remaining_quantity,
  output logic        out_rested
);
  import lobm_pkg::*;

  dp_op_t   op;
  dp_stat_t stat;

  // sequencer: owns the state machine and the input handshake
  lobm_ctrl u_ctrl (
    .clk,
    .rst_n,
    .in_valid,
    .stat,
    .op,
    .in_ready
  );

  // datapath: book memories, trade math and result register
  lobm_dp u_dp (
    .clk,
    .rst_n,
    .op,
    .in_command,
    .in_side,
    .in_limit_price,
    .in_quantity,
    .in_order_id,
    .out_ready,
    .stat,
    .out_valid,
    .out_fill_count,
    .out_remaining_quantity,
    .out_rested
  );

endmodule
